>>> design/svu_pkg.sv
// ----------------------------------------------------------------------------
// svu_pkg
// Shared types and constants of the softmax vector unit: beat payloads,
// divider request/response, fixed-point constants and register map.
// ----------------------------------------------------------------------------
package svu_pkg;

  // Input beat: one signed Q4.11 logit and its end-of-vector mark
  typedef struct packed {
    logic signed [15:0] sample;
    logic               is_last;
  } in_item_t;

  // Output beat: Q1.15 probability with vector flags
  typedef struct packed {
    logic [15:0] probability;
    logic        final_flag;
    logic        overrun;
  } out_item_t;

  // Shared divider widths
  localparam int DVD_W = 31;
  localparam int DVS_W = 22;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // 1.0 in Q1.30, and exp(-1) in Q1.30
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [28:0] EXP_C   = 29'd395007543;
  localparam logic [4:0]  SERIES_TERMS = 5'd16;

  // Register map (byte addresses)
  localparam int          PADDR_W   = 2;
  localparam logic [1:0]  ADDR_MODE = 2'd0;

endpackage

>>> design/svu_ram.sv
// ----------------------------------------------------------------------------
// svu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/svu_div.sv
// ----------------------------------------------------------------------------
// svu_div
// Shared restoring divider: one quotient bit per cycle. Serves both the
// series terms and the final normalization.
// ----------------------------------------------------------------------------
module svu_div
  import svu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic [4:0]       steps;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic             done;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem, dvd[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= 5'(DVD_W - 1);
        dvd   <= req.dividend;
        dvs   <= req.divisor;
        rem   <= '0;
      end else if (busy) begin
        rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], ge};
        if (steps == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          steps <= steps - 5'd1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

>>> design/svu_top.sv
// ----------------------------------------------------------------------------
// softmax_vector_unit_top
// Softmax over a stored vector of Q4.11 logits, one or four interleaved groups.
// ----------------------------------------------------------------------------
// Samples are taken one beat per cycle while the unit is idle and stored; a
// beat carrying is_last closes the vector and the unit stalls its input until
// every probability has been handed out. Processing runs under one sequencer
// around a shared restoring divider (31 steps per division). The max pass
// reads and compares each element. The exp pass runs 16 series terms per
// element, each a multiply and a division, then n = (max-x) >> 11 multiplies
// by exp(-1), each a low multiply, a high multiply and an add. The normalize
// pass runs one division per element and waits out any output stall.
// With interleave_mode set, element i is normalized within group i mod 4.
// Beats beyond MAX_LEN are dropped and flag overrun on every result of that
// vector.
// ----------------------------------------------------------------------------
module softmax_vector_unit_top
  import svu_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MAX_RD, S_MAX_CMP, S_EXP_RD, S_EXP_SET, S_TERM_MUL, S_TERM_DIV,
    S_CMUL_LO, S_CMUL_HI, S_CMUL_ADD, S_EXP_WR, S_NRM_RD, S_NRM_SET,
    S_NRM_DIV, S_NRM_OUT
  } state_t;

  state_t             state;
  logic               mode;
  logic               mode_lat;
  logic [CW-1:0]      count;
  logic               ovr;
  logic [CW-1:0]      idx;
  logic signed [15:0] gmax [4];
  logic [21:0]        gsum [4];

  logic [10:0]        r_q;
  logic [4:0]         n_q;
  logic [4:0]         k;
  logic [30:0]        term;
  logic [30:0]        v;
  logic [41:0]        prod;
  logic [44:0]        acc_lo;
  logic [43:0]        acc_hi;
  logic [DVD_W-1:0]   nrm_dvd;
  logic [15:0]        p_q;
  logic               div_go;

  logic               in_acc;
  logic               has_room;
  logic [1:0]         g;
  logic [CW-1:0]      idx_inc;
  logic               last_elem;
  logic [15:0]        smp_rdata;
  logic [15:0]        exp_rdata;
  logic signed [16:0] diff;
  logic [31:0]        v_rnd;
  logic [15:0]        e_val;
  logic [60:0]        cmul_sum;
  logic [DVD_W-1:0]   q_val;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // handshake and element bookkeeping
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign has_room  = (count < CW'(MAX_LEN));
  assign g         = mode_lat ? idx[1:0] : 2'd0;
  assign idx_inc   = idx + CW'(1);
  assign last_elem = (idx_inc == count);

  // datapath helpers
  assign diff     = 17'(gmax[g]) - 17'($signed(smp_rdata));
  assign v_rnd    = {1'b0, v} + 32'h0000_4000;
  assign e_val    = v_rnd[30:15];
  assign cmul_sum = 61'(acc_lo) + (61'(acc_hi) << 16) + 61'h2000_0000;
  assign q_val    = div_rsp.quotient;

  // shared divider request
  always_comb begin
    div_req.start = div_go;
    if (state == S_TERM_DIV) begin
      div_req.dividend = prod[41:11];
      div_req.divisor  = {17'b0, k};
    end else begin
      div_req.dividend = nrm_dvd;
      div_req.divisor  = gsum[g];
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODE) ? {31'b0, mode} : 32'b0;

  svu_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_smp_ram (
    .clk   (clk),
    .we    (in_acc & has_room),
    .waddr (count[AW-1:0]),
    .wdata (in_data.sample),
    .raddr (idx[AW-1:0]),
    .rdata (smp_rdata)
  );

  svu_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_exp_ram (
    .clk   (clk),
    .we    (state == S_EXP_WR),
    .waddr (idx[AW-1:0]),
    .wdata (e_val),
    .raddr (idx[AW-1:0]),
    .rdata (exp_rdata)
  );

  svu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= 1'b0;
      mode_lat  <= 1'b0;
      count     <= '0;
      ovr       <= 1'b0;
      idx       <= '0;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        gmax[i] <= -16'sd32768;
        gsum[i] <= '0;
      end
    end else begin
      div_go <= 1'b0;
      // output beat taken; S_NRM_OUT handles out_valid itself
      if (out_valid && !out_stall && state != S_NRM_OUT) begin
        out_valid <= 1'b0;
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_MODE) begin
        mode <= pwdata[0];
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (has_room) begin
              count <= count + CW'(1);
            end else begin
              ovr <= 1'b1;
            end
            if (in_data.is_last) begin
              mode_lat <= mode;
              idx      <= '0;
              state    <= S_MAX_RD;
            end
          end
        end

        // max pass
        S_MAX_RD: state <= S_MAX_CMP;
        S_MAX_CMP: begin
          if ($signed(smp_rdata) > gmax[g]) begin
            gmax[g] <= $signed(smp_rdata);
          end
          if (last_elem) begin
            idx <= '0;
            state <= S_EXP_RD;
          end else begin
            idx <= idx_inc;
            state <= S_MAX_RD;
          end
        end

        // exp pass
        S_EXP_RD: state <= S_EXP_SET;
        S_EXP_SET: begin
          r_q   <= diff[10:0];
          n_q   <= diff[15:11];
          term  <= ONE_Q30;
          v     <= ONE_Q30;
          k     <= 5'd1;
          state <= S_TERM_MUL;
        end
        S_TERM_MUL: begin
          prod   <= {11'b0, term} * {31'b0, r_q};
          div_go <= 1'b1;
          state  <= S_TERM_DIV;
        end
        S_TERM_DIV: begin
          if (div_rsp.done) begin
            term <= q_val;
            if (k[0]) begin
              v <= (q_val > v) ? 31'b0 : v - q_val;
            end else begin
              v <= v + q_val;
            end
            if (k == SERIES_TERMS) begin
              state <= (n_q == 5'd0) ? S_EXP_WR : S_CMUL_LO;
            end else begin
              k <= k + 5'd1;
              state <= S_TERM_MUL;
            end
          end
        end
        S_CMUL_LO: begin
          acc_lo <= {29'b0, v[15:0]} * {16'b0, EXP_C};
          state  <= S_CMUL_HI;
        end
        S_CMUL_HI: begin
          acc_hi <= {29'b0, v[30:16]} * {15'b0, EXP_C};
          state  <= S_CMUL_ADD;
        end
        S_CMUL_ADD: begin
          v   <= cmul_sum[60:30];
          n_q <= n_q - 5'd1;
          state <= (n_q == 5'd1) ? S_EXP_WR : S_CMUL_LO;
        end
        S_EXP_WR: begin
          gsum[g] <= gsum[g] + 22'(e_val);
          if (last_elem) begin
            idx <= '0;
            state <= S_NRM_RD;
          end else begin
            idx <= idx_inc;
            state <= S_EXP_RD;
          end
        end

        // normalize pass
        S_NRM_RD: state <= S_NRM_SET;
        S_NRM_SET: begin
          nrm_dvd <= {exp_rdata, 15'b0} + 31'(gsum[g] >> 1);
          div_go  <= 1'b1;
          state   <= S_NRM_DIV;
        end
        S_NRM_DIV: begin
          if (div_rsp.done) begin
            p_q   <= (gsum[g] == 22'd0) ? 16'd0 : q_val[15:0];
            state <= S_NRM_OUT;
          end
        end
        S_NRM_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data.probability <= p_q;
            out_data.final_flag  <= last_elem;
            out_data.overrun     <= ovr;
            if (last_elem) begin
              count <= '0;
              ovr   <= 1'b0;
              idx   <= '0;
              for (int i = 0; i < 4; i++) begin
                gmax[i] <= -16'sd32768;
                gsum[i] <= '0;
              end
              state <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= S_NRM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
